>>> sv/adam7_pass_scatter_addresser_macros.svh
// Assertion macros shared by the Adam7 pass scatter addresser RTL
`ifndef ADAM7_PASS_SCATTER_ADDRESSER_MACROS_SVH
`define ADAM7_PASS_SCATTER_ADDRESSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define A7PSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define A7PSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/a7psa_pkg.sv
// Shared types, constants and helpers for the Adam7 pass scatter addresser
package a7psa_pkg;

    localparam int unsigned DIM_W      = 13;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned CNT_W      = 24;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned PASS_W     = 3;
    localparam int unsigned PASS_COUNT = 7;
    localparam int unsigned TILE       = 8;
    localparam int unsigned TILE_W     = 3;

    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [PASS_W-1:0] pass_t;
    typedef cnt_t [PASS_COUNT-1:0] cnt_arr_t;

    localparam dim_t MIN_DIM   = 13'd1;
    localparam dim_t MAX_DIM   = 13'd4096;
    localparam dim_t DIM_RESET = 13'd8;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        pass_t pass_number;
        cnt_t  pass_index;
        cnt_t  stream_offset;
        pix_t  pixel_out;
        logic  image_done;
    } result_t;

    // Adam7 mask, indexed [row mod 8][column mod 8]
    localparam pass_t PASS_MAP [TILE][TILE] = '{
        '{3'd1, 3'd6, 3'd4, 3'd6, 3'd2, 3'd6, 3'd4, 3'd6},
        '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
        '{3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
        '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
        '{3'd3, 3'd6, 3'd4, 3'd6, 3'd3, 3'd6, 3'd4, 3'd6},
        '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
        '{3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
        '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}
    };

    function automatic dim_t clamp_dim(input dim_t v);
        dim_t r;
        if (v < MIN_DIM)
        begin
            r = MIN_DIM;
        end
        else if (v > MAX_DIM)
        begin
            r = MAX_DIM;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> sv/a7psa_base_calc.sv
// Pass base sequencer: one shared multiplier steps through the seven pass sizes
module a7psa_base_calc
    import a7psa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     restart,
    input  dim_t     image_width,
    input  dim_t     image_height,
    output logic     busy,
    output cnt_arr_t bases
);

    localparam pass_t LAST_STEP = 3'd7;

    logic             busy_reg;
    pass_t            step_reg;
    cnt_t             acc_reg;
    cnt_t             prod_reg;
    cnt_arr_t         base_reg;

    dim_t             w;
    dim_t             h;
    logic [DIM_W:0]   w1;
    logic [DIM_W:0]   w3;
    logic [DIM_W:0]   w7;
    logic [DIM_W:0]   h1;
    logic [DIM_W:0]   h3;
    logic [DIM_W:0]   h7;
    dim_t             hf;
    dim_t             wf;
    logic [2*DIM_W-1:0] prod_full;
    cnt_t             size_next;
    cnt_t             acc_sum;

    always_comb
    begin
        w  = clamp_dim(image_width);
        h  = clamp_dim(image_height);
        w1 = {1'b0, w} + 14'd1;
        w3 = {1'b0, w} + 14'd3;
        w7 = {1'b0, w} + 14'd7;
        h1 = {1'b0, h} + 14'd1;
        h3 = {1'b0, h} + 14'd3;
        h7 = {1'b0, h} + 14'd7;
        case (step_reg)
            3'd0:
            begin
                hf = DIM_W'(h7 >> 3);
                wf = DIM_W'(w7 >> 3);
            end
            3'd1:
            begin
                hf = DIM_W'(h7 >> 3);
                wf = DIM_W'(w3 >> 3);
            end
            3'd2:
            begin
                hf = DIM_W'(h3 >> 3);
                wf = DIM_W'(w3 >> 2);
            end
            3'd3:
            begin
                hf = DIM_W'(h3 >> 2);
                wf = DIM_W'(w1 >> 2);
            end
            3'd4:
            begin
                hf = DIM_W'(h1 >> 2);
                wf = DIM_W'(w1 >> 1);
            end
            3'd5:
            begin
                hf = DIM_W'(h1 >> 1);
                wf = w >> 1;
            end
            3'd6:
            begin
                hf = h >> 1;
                wf = w;
            end
            default:
            begin
                hf = '0;
                wf = '0;
            end
        endcase
        prod_full = hf * wf;
        size_next = prod_full[CNT_W-1:0];
        acc_sum   = acc_reg + prod_reg;
    end

    // step s: latch size(s); accumulate size(s-1) into base(s)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            acc_reg  <= '0;
            base_reg <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd0)
            begin
                acc_reg <= acc_sum;
                if (step_reg != LAST_STEP)
                begin
                    base_reg[step_reg] <= acc_sum;
                end
            end
            if (step_reg != LAST_STEP)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && step_reg != LAST_STEP)
        begin
            prod_reg <= size_next;
        end
    end

    assign busy  = busy_reg;
    assign bases = base_reg;

endmodule

>>> sv/a7psa_pass_track.sv
// Raster position, per-pass counters and per-pixel pass/offset datapath
module a7psa_pass_track
    import a7psa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic     frame_start,
    input  pix_t     pixel_value,
    input  dim_t     image_width,
    input  dim_t     image_height,
    input  cnt_arr_t new_bases,
    output result_t  result
);

    pos_t     row_reg;
    pos_t     col_reg;
    cnt_arr_t cnt_reg;
    cnt_arr_t base_reg;

    pos_t     row_next;
    pos_t     col_next;
    cnt_arr_t cnt_next;

    dim_t     w;
    dim_t     h;
    pos_t     row_cur;
    pos_t     col_cur;
    cnt_arr_t cnt_cur;
    cnt_arr_t base_cur;
    pass_t    pass;
    pass_t    slot;
    cnt_t     idx;
    dim_t     col_inc;
    dim_t     row_inc;
    logic     col_end;
    logic     row_end;
    logic     done;

    always_comb
    begin
        w        = clamp_dim(image_width);
        h        = clamp_dim(image_height);
        row_cur  = frame_start ? '0 : row_reg;
        col_cur  = frame_start ? '0 : col_reg;
        cnt_cur  = frame_start ? '0 : cnt_reg;
        base_cur = frame_start ? new_bases : base_reg;

        pass = PASS_MAP[row_cur[TILE_W-1:0]][col_cur[TILE_W-1:0]];
        slot = pass - 3'd1;
        idx  = cnt_cur[slot];

        col_inc = {1'b0, col_cur} + 13'd1;
        row_inc = {1'b0, row_cur} + 13'd1;
        col_end = col_inc >= w;
        row_end = row_inc >= h;
        done    = col_end && row_end;

        cnt_next       = cnt_cur;
        cnt_next[slot] = idx + 24'd1;
        row_next       = row_cur;
        col_next       = col_cur + 12'd1;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_cur + 12'd1;
            if (row_end)
            begin
                row_next = '0;
                cnt_next = '0;
            end
        end

        result.pass_number   = pass;
        result.pass_index    = idx;
        result.stream_offset = base_cur[slot] + idx;
        result.pixel_out     = pixel_value;
        result.image_done    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            cnt_reg  <= '0;
            base_reg <= '0;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            base_reg <= base_cur;
        end
    end

endmodule

>>> sv/a7psa_out_buf.sv
// Result register with a one-entry skid stage
module a7psa_out_buf
    import a7psa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    full,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_fire;

    assign out_fire = out_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (load)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (load)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_reg <= load_data;
            end
            else
            begin
                out_data_reg <= load_data;
            end
        end
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

>>> sv/adam7_pass_scatter_addresser.sv
// Top level of the Adam7 pass scatter addresser. Takes one grayscale pixel per
// clock in raster order while pixel_stall is low and returns, via the result
// register or the skid stage, its Adam7 pass (1..7), its index within that pass
// and its byte offset in the pass-ordered payload; the pass lookup, counter
// increment and base add all sit between the position/counter registers and
// the result register. Pass bases are latched on a pixel with frame_start set;
// a sequencer with one shared multiplier supplies them and is busy after reset
// and each configuration write, holding pixel_stall high. A one-entry skid stage
// lets a pixel be taken while a finished result still waits on result_stall.
`include "adam7_pass_scatter_addresser_macros.svh"

module adam7_pass_scatter_addresser
    import a7psa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [DIM_W-1:0]    cfg_data,

    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  logic [PIX_W-1:0]    pixel_value,
    input  logic                frame_start,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [PASS_W-1:0]   pass_number,
    output logic [CNT_W-1:0]    pass_index,
    output logic [CNT_W-1:0]    stream_offset,
    output logic [PIX_W-1:0]    pixel_out,
    output logic                image_done
);

    dim_t     width_reg;
    dim_t     height_reg;
    logic     calc_busy;
    cnt_arr_t calc_bases;
    logic     skid_full;
    logic     accept;
    result_t  track_result;
    result_t  out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    assign pixel_stall = calc_busy || skid_full;
    assign accept      = pixel_valid && !pixel_stall;

    a7psa_base_calc u_base_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_we),
        .image_width  (width_reg),
        .image_height (height_reg),
        .busy         (calc_busy),
        .bases        (calc_bases)
    );

    a7psa_pass_track u_pass_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (frame_start),
        .pixel_value  (pixel_value),
        .image_width  (width_reg),
        .image_height (height_reg),
        .new_bases    (calc_bases),
        .result       (track_result)
    );

    a7psa_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .load_data    (track_result),
        .full         (skid_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (out_result)
    );

    assign pass_number   = out_result.pass_number;
    assign pass_index    = out_result.pass_index;
    assign stream_offset = out_result.stream_offset;
    assign pixel_out     = out_result.pixel_out;
    assign image_done    = out_result.image_done;

    `A7PSA_ASSERT_IMP(a_busy_stalls, calc_busy, pixel_stall, "pixel taken during base calc")
    `A7PSA_ASSERT_NXT(a_cfg_stalls, cfg_we, pixel_stall, "no stall after config write")
    `A7PSA_ASSERT_NXT(a_accept_shows, accept, result_valid, "accepted transaction lost")
    `A7PSA_ASSERT_IMP(a_pass_range, result_valid, pass_number != 3'd0, "pass number zero")

endmodule
